[rtl/core/vcc_pkg.sv]
package vcc_pkg;

  // Block configuration defaults
  localparam int CURVE_COUNT  = 15;
  localparam int SAMPLE_BITS  = 12;
  localparam int CURVE_LENGTH = 128;

  // Field widths
  localparam int SRC_W       = 12;
  localparam int TGT_W       = 7;
  localparam int ENTRY_W     = 7;
  localparam int CURVE_IDX_W = 4;
  localparam int FRAC_W      = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;

  // Derived arithmetic widths
  localparam int DIV_STEPS = TGT_W + FRAC_W;           // quotient bits
  localparam int NUM_W     = SRC_W + TGT_W + FRAC_W;   // dividend bits
  localparam int PROD_W    = 2 * (ENTRY_W + 1);        // interpolation product
  localparam int ROW_W     = ENTRY_W - 1;              // row inside one bank
  localparam int BANK_ROWS = CURVE_LENGTH / 2;         // entries of one curve per bank

  // Register reset values
  localparam logic [SRC_W-1:0] SRC_MIN_RST = '0;
  localparam logic [SRC_W-1:0] SRC_MAX_RST = '1;
  localparam logic [TGT_W-1:0] TGT_MIN_RST = '0;
  localparam logic [TGT_W-1:0] TGT_MAX_RST = '1;

  typedef enum logic [1:0] {
    OP_CURVE  = 2'd0,
    OP_LINEAR = 2'd1,
    OP_WRITE  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_MIN = 2'd0,
    CFG_SRC_MAX = 2'd1,
    CFG_TGT_MIN = 2'd2,
    CFG_TGT_MAX = 2'd3
  } cfg_reg_e;

  // One request as it travels down the pipeline
  typedef struct packed {
    op_e                       op;
    logic [CURVE_IDX_W-1:0]    curve;
    logic [ENTRY_W-1:0]        offset;
    logic [ENTRY_W-1:0]        data;
    logic                      bad;
    logic                      empty;
    logic [SRC_W-1:0]          delta;
    logic [SRC_W-1:0]          span;
    logic [TGT_W-1:0]          tmag;
    logic                      tneg;
    logic [SRC_W-1:0]          rem;
    logic [DIV_STEPS-1:0]      nlo;
    logic [DIV_STEPS-1:0]      quo;
    logic [DIV_STEPS-1:0]      pos;
    logic [ENTRY_W-1:0]        e0;
    logic signed [PROD_W-1:0]  prod;
  } pipe_t;

endpackage

[rtl/core/vcc_ram.sv]
module vcc_ram #(
  parameter int Width = vcc_pkg::ENTRY_W,
  parameter int Depth = vcc_pkg::BANK_ROWS
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/velocity_curve_converter_top.sv]
// Velocity curve converter.
// Input channel (in_valid_i/in_ready_o) takes one request per cycle while
// in_ready_o is high: a curve or linear conversion of a sensor sample, a
// curve entry write, or an entry read. Output channel (out_valid_o/out_ready_i)
// returns one result per request, in request order.
// Throughput: one request per cycle while in_ready_o is high. Every request
// makes a single pass through a 21-stage pipeline (14 of them a
// one-bit-per-stage divider) and a single access to each of the two curve
// memory banks (even and odd entries).
// Reset: the window/target registers return to their defaults, and a clearing
// pass loads every curve with the identity, one row of both banks per cycle.
// in_ready_o stays low while the clearing pass runs;
// configuration writes are taken at any time.
// Stall: when out_ready_i is low the output register holds; the pipeline
// keeps filling its empty stages, so requests are still accepted until every
// stage is occupied.
// Configuration must be written with no request in flight (not enforced).
module velocity_curve_converter_top #(
  parameter int CurveCount = vcc_pkg::CURVE_COUNT,
  parameter int SampleBits = vcc_pkg::SAMPLE_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [vcc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [vcc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  vcc_pkg::op_e                      op_i,
  input  logic [SampleBits-1:0]             sample_i,
  input  logic [vcc_pkg::CURVE_IDX_W-1:0]   curve_index_i,
  input  logic [vcc_pkg::ENTRY_W-1:0]       entry_offset_i,
  input  logic [vcc_pkg::ENTRY_W-1:0]       entry_data_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [vcc_pkg::ENTRY_W-1:0]       result_o,
  output logic                              index_error_o
);

  import vcc_pkg::*;

  localparam int BankDepth = CurveCount * BANK_ROWS;
  localparam int AW        = $clog2(BankDepth);
  localparam int SW        = (SampleBits > SRC_W) ? SampleBits : SRC_W;

  // Pipeline stage positions
  localparam int ST_IN    = 0;
  localparam int ST_CLAMP = 1;
  localparam int ST_MUL   = 2;
  localparam int ST_DIV0  = 3;
  localparam int ST_POS   = ST_DIV0 + DIV_STEPS;
  localparam int ST_RAM   = ST_POS + 1;
  localparam int ST_IMUL  = ST_RAM + 1;
  localparam int ST_OUT   = ST_IMUL + 1;
  localparam int NUM_ST   = ST_OUT + 1;

  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(CURVE_LENGTH - 1);

  // Restoring division, one quotient bit per stage
  function automatic pipe_t div_step(pipe_t p);
    logic [SRC_W:0] trial;
    logic [SRC_W:0] diff;
    pipe_t          o;
    o     = p;
    trial = {p.rem, p.nlo[DIV_STEPS-1]};
    diff  = trial - {1'b0, p.span};
    if (trial >= {1'b0, p.span}) begin
      o.rem = diff[SRC_W-1:0];
      o.quo = {p.quo[DIV_STEPS-2:0], 1'b1};
    end else begin
      o.rem = trial[SRC_W-1:0];
      o.quo = {p.quo[DIV_STEPS-2:0], 1'b0};
    end
    o.nlo = {p.nlo[DIV_STEPS-2:0], 1'b0};
    return o;
  endfunction

  logic [SRC_W-1:0]      src_min_q, src_max_q;
  logic [TGT_W-1:0]      tgt_min_q, tgt_max_q;

  logic                  clr_busy_q;
  logic [AW-1:0]         clr_addr_q;

  logic [NUM_ST-1:0]     v_q, v_d, ld;
  pipe_t                 pl_q [ST_OUT];
  pipe_t                 pl_d [ST_OUT];
  logic [SampleBits-1:0] sample_q;

  logic [ENTRY_W-1:0]    result_q, result_d;
  logic                  err_q, err_d;

  logic [ENTRY_W-1:0]    p_idx;
  logic [ROW_W-1:0]      row_even, row_odd;
  logic [AW-1:0]         addr_even, addr_odd;
  logic                  wr_req;
  logic                  even_we, odd_we;
  logic [AW-1:0]         even_waddr, odd_waddr;
  logic [ENTRY_W-1:0]    even_wdata, odd_wdata;
  logic [ENTRY_W-1:0]    rd_even, rd_odd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_min_q <= SRC_MIN_RST;
      src_max_q <= SRC_MAX_RST;
      tgt_min_q <= TGT_MIN_RST;
      tgt_max_q <= TGT_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_SRC_MIN: src_min_q <= cfg_wdata_i[SRC_W-1:0];
        CFG_SRC_MAX: src_max_q <= cfg_wdata_i[SRC_W-1:0];
        CFG_TGT_MIN: tgt_min_q <= cfg_wdata_i[TGT_W-1:0];
        CFG_TGT_MAX: tgt_max_q <= cfg_wdata_i[TGT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clearing pass: identity into every row of both banks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AW'(BankDepth - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  // Stage k may load when it or any later stage has a hole, or the output drains
  always_comb begin : stall_chain
    logic [NUM_ST-1:0] later;
    for (int k = 0; k < NUM_ST; k++) begin
      later = {NUM_ST{1'b1}} << k;
      ld[k] = out_ready_i | (|(~v_q & later));
    end
  end

  assign in_ready_o = ld[ST_IN] & ~clr_busy_q;
  assign v_d        = {v_q[NUM_ST-2:0], in_valid_i & in_ready_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NUM_ST; k++) begin
        if (ld[k]) v_q[k] <= v_d[k];
      end
    end
  end

  // Input register
  always_comb begin
    pl_d[ST_IN]        = '0;
    pl_d[ST_IN].op     = op_i;
    pl_d[ST_IN].curve  = curve_index_i;
    pl_d[ST_IN].offset = entry_offset_i;
    pl_d[ST_IN].data   = entry_data_i;
  end

  // Clamp to the window, distance from src_min and window span
  always_comb begin : clamp_stage
    logic             inv;
    logic [SRC_W-1:0] lo, hi, s;
    logic [SW-1:0]    smp;
    inv = src_min_q > src_max_q;
    lo  = inv ? src_max_q : src_min_q;
    hi  = inv ? src_min_q : src_max_q;
    smp = SW'(sample_q);
    if (smp < SW'(lo)) begin
      s = lo;
    end else if (smp > SW'(hi)) begin
      s = hi;
    end else begin
      s = smp[SRC_W-1:0];
    end
    pl_d[ST_CLAMP]       = pl_q[ST_IN];
    pl_d[ST_CLAMP].delta = inv ? (src_min_q - s) : (s - src_min_q);
    pl_d[ST_CLAMP].span  = inv ? (src_min_q - src_max_q) : (src_max_q - src_min_q);
    pl_d[ST_CLAMP].tneg  = tgt_min_q > tgt_max_q;
    pl_d[ST_CLAMP].tmag  = (tgt_min_q > tgt_max_q) ? (tgt_min_q - tgt_max_q)
                                                   : (tgt_max_q - tgt_min_q);
    pl_d[ST_CLAMP].empty = src_min_q == src_max_q;
    pl_d[ST_CLAMP].bad   = {1'b0, pl_q[ST_IN].curve} >= (CURVE_IDX_W + 1)'(CurveCount);
  end

  // Dividend: distance times target span, scaled by 128 in curve mode
  always_comb begin : mul_stage
    logic [SRC_W+TGT_W-1:0] mprod;
    logic [NUM_W-1:0]       numer;
    mprod = pl_q[ST_CLAMP].delta * pl_q[ST_CLAMP].tmag;
    numer = (pl_q[ST_CLAMP].op == OP_CURVE) ? {mprod, {FRAC_W{1'b0}}} : NUM_W'(mprod);
    pl_d[ST_MUL]     = pl_q[ST_CLAMP];
    pl_d[ST_MUL].rem = numer[NUM_W-1 -: SRC_W];
    pl_d[ST_MUL].nlo = numer[DIV_STEPS-1:0];
    pl_d[ST_MUL].quo = '0;
  end

  // Divider stages
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    assign pl_d[ST_DIV0 + j] = div_step(pl_q[ST_DIV0 + j - 1]);
  end

  // Mapped position: target minimum plus or minus the quotient
  always_comb begin : pos_stage
    logic [DIV_STEPS-1:0] base;
    pipe_t                src;
    src  = pl_q[ST_POS-1];
    base = (src.op == OP_CURVE) ? {tgt_min_q, {FRAC_W{1'b0}}} : DIV_STEPS'(tgt_min_q);
    pl_d[ST_POS]     = src;
    pl_d[ST_POS].pos = src.tneg ? (base - src.quo) : (base + src.quo);
  end

  // Memory access: entry p and p+1 always sit in opposite banks
  assign p_idx     = (pl_q[ST_POS].op == OP_CURVE) ? pl_q[ST_POS].pos[DIV_STEPS-1 -: ENTRY_W]
                                                    : pl_q[ST_POS].offset;
  assign row_odd   = p_idx[ENTRY_W-1:1];
  assign row_even  = p_idx[ENTRY_W-1:1] + ROW_W'(p_idx[0]);
  assign addr_even = AW'({pl_q[ST_POS].curve, row_even});
  assign addr_odd  = AW'({pl_q[ST_POS].curve, row_odd});
  assign wr_req    = ld[ST_RAM] & v_q[ST_POS] & (pl_q[ST_POS].op == OP_WRITE)
                   & ~pl_q[ST_POS].bad;

  assign even_we    = clr_busy_q | (wr_req & ~p_idx[0]);
  assign odd_we     = clr_busy_q | (wr_req & p_idx[0]);
  assign even_waddr = clr_busy_q ? clr_addr_q : addr_even;
  assign odd_waddr  = clr_busy_q ? clr_addr_q : addr_odd;
  assign even_wdata = clr_busy_q ? {clr_addr_q[ROW_W-1:0], 1'b0} : pl_q[ST_POS].data;
  assign odd_wdata  = clr_busy_q ? {clr_addr_q[ROW_W-1:0], 1'b1} : pl_q[ST_POS].data;

  vcc_ram #(
    .Width (ENTRY_W),
    .Depth (BankDepth)
  ) u_bank_even (
    .clk_i   (clk_i),
    .we_i    (even_we),
    .waddr_i (even_waddr),
    .wdata_i (even_wdata),
    .re_i    (ld[ST_RAM]),
    .raddr_i (addr_even),
    .rdata_o (rd_even)
  );

  vcc_ram #(
    .Width (ENTRY_W),
    .Depth (BankDepth)
  ) u_bank_odd (
    .clk_i   (clk_i),
    .we_i    (odd_we),
    .waddr_i (odd_waddr),
    .wdata_i (odd_wdata),
    .re_i    (ld[ST_RAM]),
    .raddr_i (addr_odd),
    .rdata_o (rd_odd)
  );

  assign pl_d[ST_RAM] = pl_q[ST_POS];

  // Interpolation product (e1 - e0) * frac
  always_comb begin : imul_stage
    pipe_t                   src;
    logic                    p0;
    logic [ENTRY_W-1:0]      e0, e1;
    logic signed [ENTRY_W:0] diff, frac_s;
    src    = pl_q[ST_RAM];
    p0     = (src.op == OP_CURVE) ? src.pos[FRAC_W] : src.offset[0];
    e0     = p0 ? rd_odd : rd_even;
    e1     = p0 ? rd_even : rd_odd;
    diff   = $signed({1'b0, e1}) - $signed({1'b0, e0});
    frac_s = $signed({1'b0, src.pos[FRAC_W-1:0]});
    pl_d[ST_IMUL]      = src;
    pl_d[ST_IMUL].e0   = e0;
    pl_d[ST_IMUL].prod = diff * frac_s;
  end

  // Result select per operation
  always_comb begin : out_stage
    pipe_t                    src;
    logic signed [PROD_W-1:0] adj, shr;
    logic [PROD_W-1:0]        sum;
    logic [ENTRY_W-1:0]       interp;
    src    = pl_q[ST_IMUL];
    adj    = src.prod[PROD_W-1] ? (src.prod + ROUND_BIAS) : src.prod;
    shr    = adj >>> FRAC_W;
    sum    = $unsigned(shr) + PROD_W'(src.e0);
    interp = sum[ENTRY_W-1:0];
    result_d = '0;
    err_d    = 1'b0;
    unique case (src.op)
      OP_CURVE: begin
        if (src.bad) begin
          err_d = 1'b1;
        end else if (src.empty) begin
          result_d = tgt_min_q;
        end else begin
          result_d = interp;
        end
      end
      OP_LINEAR: begin
        result_d = src.empty ? tgt_min_q : src.pos[ENTRY_W-1:0];
      end
      OP_WRITE: begin
        err_d = src.bad;
      end
      OP_READ: begin
        if (src.bad) begin
          err_d = 1'b1;
        end else begin
          result_d = src.e0;
        end
      end
      default: ;
    endcase
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < ST_OUT; k++) begin
      if (ld[k]) pl_q[k] <= pl_d[k];
    end
    if (ld[ST_IN]) begin
      sample_q <= sample_i;
    end
    if (ld[ST_OUT]) begin
      result_q <= result_d;
      err_q    <= err_d;
    end
  end

  assign out_valid_o   = v_q[ST_OUT];
  assign result_o      = result_q;
  assign index_error_o = err_q;

endmodule

[rtl/core/vcc_checker.sv]
module vcc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [vcc_pkg::ENTRY_W-1:0]  result_o,
  input logic                         index_error_o
);

  logic [7:0] pend_q;

  // Requests taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 8'(in_valid_i & in_ready_o) - 8'(out_valid_o & out_ready_i);
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o)
                                     && $stable(index_error_o))
    else $error("result changed while stalled");

  // A result flagged with an index error carries a cleared result value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_error_o |-> result_o == '0)
    else $error("index error with nonzero result");

  // Curve memory is still being loaded right after reset
  a_init_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("request taken during curve clearing");

  // No result without an outstanding request
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("result without a request");

endmodule

bind velocity_curve_converter_top vcc_checker u_vcc_checker (.*);
